[rtl/core/tvf_pkg.sv]
`default_nettype none

package tvf_pkg;

  // Widths of the fixed-point fields and of the fusion arithmetic.
  localparam int unsigned DIST_W   = 16;  // Q5.10 signed distance
  localparam int unsigned WEIGHT_W = 16;  // Q8.8 weight
  localparam int unsigned TRUNC_W  = 15;
  localparam int unsigned SUM_W    = 17;  // exact weight sum, also the divisor
  localparam int unsigned PROD_W   = 33;  // signed distance times unsigned weight
  localparam int unsigned NUM_W    = 34;  // sum of two products
  localparam int unsigned MAG_W    = 33;  // magnitude of the numerator
  localparam int unsigned QUO_W    = 17;  // quotient magnitude, at most 2^15

  localparam logic [TRUNC_W-1:0]  TRUNC_RESET    = 15'd307;
  localparam logic [WEIGHT_W-1:0] W_THRESH_RESET = 16'd0;

  // Request kinds carried in the input tuser.
  localparam logic REQ_FUSE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register select, taken from address bit 2.
  localparam logic REG_TRUNC    = 1'b0;
  localparam logic REG_W_THRESH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [WEIGHT_W-1:0]      weight;
  } voxel_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/tvf_ram.sv]
`default_nettype none

module tvf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/tvf_div.sv]
`default_nettype none

module tvf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tvf_pkg::div_req_t             req_i,
  input  wire logic [tvf_pkg::MAG_W-1:0]     dividend_i,
  input  wire logic [tvf_pkg::SUM_W-1:0]     divisor_i,
  output tvf_pkg::div_rsp_t                  rsp_o
);
  import tvf_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] rem_q;
  logic [QUO_W-1:0] dq_q;
  logic [SUM_W-1:0] div_q;

  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] rem_d;
  logic [QUO_W-1:0] dq_d;
  logic             last;

  // Restoring division, one quotient bit a cycle. The caller guarantees
  // that the quotient fits in QUO_W bits, so the upper dividend bits
  // start out below the divisor.
  always_comb begin
    trial = {rem_q, dq_q[QUO_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    dq_d  = {dq_q[QUO_W-2:0], ge};
    last  = cnt_q == CNT_W'(QUO_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= SUM_W'(dividend_i[MAG_W-1:QUO_W]);
      dq_q  <= dividend_i[QUO_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

`default_nettype wire

[rtl/core/tsdf_voxel_fusion.sv]
// Truncated signed distance fusion over a dense cubic voxel window.
//
// Items enter on the s_axis channel (one beat per item) and one result beat
// leaves on m_axis for every item. A fuse item with a distance above minus
// the truncation and a nonzero weight sum clips the distance to the
// truncation, merges it into the voxel by a weighted running average and
// writes the voxel back; other fuse items are skipped. A read item returns
// the stored distance when the voxel weight exceeds the minimum weight,
// else the truncation background. Both registers are to be written by the
// user over the APB port only while no item is in flight; the block itself
// does not enforce this.
//
// One item is worked on at a time. A read item or a skipped fuse passes
// through the EVAL and DONE states; an applied fuse also passes through SUM
// and DIV, where the radix-2 divider forms the weighted average in 17
// quotient steps. s_axis is ready again once the result beat is issued.
// The voxel memory is read at the accepting edge, and an applied fuse
// writes the voxel back as the result beat is issued, so successive items
// never overlap on the same voxel.
// After reset the block clears the weights of all 2^(3*GRID_BITS) voxels
// (32768 at the default), one voxel per cycle; s_axis is not ready until
// then, while the APB port works from the start. A result beat waits in the
// output register while m_axis_tready is low; the next item may be accepted
// meanwhile, but its result holds the block until the output register frees.
`default_nettype none

module tsdf_voxel_fusion #(
  parameter int unsigned GRID_BITS = 5
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // tdata: voxel_x, voxel_y, voxel_z, signed_distance, sample_weight, zero fill
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [((3*GRID_BITS+32+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: req_type
  input  wire logic [0:0]                              s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // tdata: distance_out, weight_out
  output logic [31:0]                                  m_axis_tdata,
  // tuser: applied, valid_res
  output logic [1:0]                                   m_axis_tuser,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [2:0]                              paddr,
  input  wire logic [31:0]                             pwdata,
  output logic [31:0]                                  prdata,
  output logic                                         pready
);
  import tvf_pkg::*;

  localparam int unsigned AW    = 3 * GRID_BITS;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned VW    = DIST_W + WEIGHT_W;

  state_e state_q, state_d;

  logic [AW-1:0]           clr_addr_q;
  logic [TRUNC_W-1:0]      trunc_q;
  logic [WEIGHT_W-1:0]     min_w_q;

  logic                    req_q;
  logic [AW-1:0]           idx_q;
  logic signed [DIST_W-1:0] sdf_q;
  logic [WEIGHT_W-1:0]     w_q;

  logic [SUM_W-1:0]        sum_q;
  logic signed [PROD_W-1:0] p_old_q, p_new_q;
  logic                    neg_q;

  logic signed [DIST_W-1:0] res_dist_q;
  logic [WEIGHT_W-1:0]     res_w_q;
  logic                    res_applied_q;
  logic                    res_valid_q;

  logic                    m_valid_q;
  logic [31:0]             m_data_q;
  logic [1:0]              m_user_q;

  logic                    in_accept;
  logic                    out_free;
  logic [AW-1:0]           in_idx;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  voxel_t                  ram_wdata;
  voxel_t                  ram_rdata;
  logic [VW-1:0]           ram_rbits;

  logic signed [DIST_W-1:0] trunc_s;
  logic [SUM_W-1:0]        sum_d;
  logic                    fuse_ok;
  logic                    rd_valid;
  logic signed [DIST_W-1:0] d_clip;
  logic signed [PROD_W-1:0] p_old_d, p_new_d;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        num_mag;
  logic signed [QUO_W:0]   q_signed;
  logic signed [DIST_W-1:0] q_sat;
  logic [WEIGHT_W-1:0]     w_sat;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    cfg_we;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= TRUNC_RESET;
      min_w_q <= W_THRESH_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_TRUNC:    trunc_q <= pwdata[TRUNC_W-1:0];
        REG_W_THRESH: min_w_q <= pwdata[WEIGHT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TRUNC:    prdata = 32'(trunc_q);
      REG_W_THRESH: prdata = 32'(min_w_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign s_axis_tready = state_q == ST_IDLE;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[AW-1:0];
  assign out_free      = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= s_axis_tuser[0];
      idx_q <= in_idx;
      sdf_q <= s_axis_tdata[AW+DIST_W-1:AW];
      w_q   <= s_axis_tdata[AW+DIST_W+WEIGHT_W-1:AW+DIST_W];
    end
  end

  // ---------------------------------------------------------------- memory
  tvf_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_idx),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = voxel_t'(ram_rbits);

  // ---------------------------------------------------------------- datapath
  always_comb begin
    trunc_s  = $signed({1'b0, trunc_q});
    sum_d    = SUM_W'(ram_rdata.weight) + SUM_W'(w_q);
    fuse_ok  = ($signed({sdf_q[DIST_W-1], sdf_q}) > -$signed({2'b00, trunc_q}))
               && (sum_d != '0);
    rd_valid = ram_rdata.weight > min_w_q;
    d_clip   = (sdf_q < trunc_s) ? sdf_q : trunc_s;
    p_old_d  = ram_rdata.distance * $signed({1'b0, ram_rdata.weight});
    p_new_d  = d_clip * $signed({1'b0, w_q});

    num      = {p_old_q[PROD_W-1], p_old_q} + {p_new_q[PROD_W-1], p_new_q};
    num_mag  = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];

    q_signed = neg_q ? -$signed({1'b0, div_rsp.quotient})
                     :  $signed({1'b0, div_rsp.quotient});
    // The average lies between the old and the clipped distance; the clamp
    // only guards the conversion to 16 bits.
    if (q_signed > $signed((QUO_W+1)'(32767))) begin
      q_sat = 16'sh7FFF;
    end else if (q_signed < -$signed((QUO_W+1)'(32768))) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q_signed[DIST_W-1:0];
    end
    w_sat = sum_q[SUM_W-1] ? '1 : sum_q[WEIGHT_W-1:0];
  end

  assign div_req.start = state_q == ST_SUM;

  tvf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (num_mag),
    .divisor_i  (sum_q),
    .rsp_o      (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      sum_q   <= sum_d;
      p_old_q <= p_old_d;
      p_new_q <= p_new_d;
      res_w_q <= ram_rdata.weight;
      res_applied_q <= 1'b0;
      if (req_q == REQ_READ) begin
        res_valid_q <= rd_valid;
        res_dist_q  <= rd_valid ? ram_rdata.distance : trunc_s;
      end else begin
        res_valid_q <= 1'b0;
        res_dist_q  <= (ram_rdata.weight != '0) ? ram_rdata.distance : trunc_s;
      end
    end
    if (state_q == ST_SUM) begin
      neg_q <= num[NUM_W-1];
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      res_dist_q    <= q_sat;
      res_w_q       <= w_sat;
      res_applied_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d            = state_q;
    ram_we             = 1'b0;
    ram_waddr          = idx_q;
    ram_wdata.distance = res_dist_q;
    ram_wdata.weight   = res_w_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we             = 1'b1;
        ram_waddr          = clr_addr_q;
        ram_wdata.distance = '0;
        ram_wdata.weight   = '0;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (req_q == REQ_FUSE && fuse_ok) begin
          state_d = ST_SUM;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SUM: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ram_we  = res_applied_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {res_w_q, res_dist_q};
      m_user_q <= {res_valid_q, res_applied_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

[rtl/core/tvf_checker.sv]
`default_nettype none

module tvf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // Only one item is in flight, so acceptance closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item was in flight");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("applied and valid_res both set");

  // An applied fuse always leaves a nonzero weight behind.
  a_applied_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:16] != 16'd0)
    else $error("applied fuse reported zero weight");

endmodule

bind tsdf_voxel_fusion tvf_checker u_tvf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
